// File: hdl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and defaults for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DepthDef    = 16;
  localparam int unsigned PrioBitsDef = 16;
  localparam int unsigned TagBitsDef  = 16;
  localparam int unsigned StatusW     = 2;

  typedef enum logic [StatusW-1:0] {
    STAT_INSERTED = 2'd0,
    STAT_DROPPED  = 2'd1,
    STAT_ENTRY    = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ROTATE = 2'd2
  } cell_op_e;

  // Link from one cell to the next one down the chain.
  typedef struct packed {
    logic valid;  // cell holds an entry
    logic keep;   // cell holds an entry of equal or higher priority than the insert
  } link_t;

endpackage
`default_nettype wire

// File: hdl/spq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels carrying queue commands and queue results.
// ----------------------------------------------------------------------------
interface spq_in_if #(
  parameter int unsigned PRIO_BITS = 16,
  parameter int unsigned TAG_BITS  = 16
);
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic signed [PRIO_BITS-1:0] prio_in;
  logic        [TAG_BITS-1:0]  tag_in;

  modport source (output valid, output mode, output prio_in, output tag_in, input ready);
  modport sink   (input valid, input mode, input prio_in, input tag_in, output ready);
endinterface

interface spq_out_if #(
  parameter int unsigned PRIO_BITS = 16,
  parameter int unsigned TAG_BITS  = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [PRIO_BITS-1:0] prio_out;
  logic        [TAG_BITS-1:0]  tag_out;
  logic        [1:0]           status;
  logic                        last_flag;

  modport source (output valid, output prio_out, output tag_out, output status,
                  output last_flag, input ready);
  modport sink   (input valid, input prio_out, input tag_out, input status,
                  input last_flag, output ready);
endinterface
`default_nettype wire

// File: hdl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, takes part in inserts and
// in the rotation that streams the chain out through slot 0.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int unsigned PRIO_BITS = spq_pkg::PrioBitsDef,
  parameter int unsigned TAG_BITS  = spq_pkg::TagBitsDef
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  spq_pkg::cell_op_e           op_i,
  input  wire  signed [PRIO_BITS-1:0] ins_prio_i,
  input  wire         [TAG_BITS-1:0]  ins_tag_i,
  input  spq_pkg::link_t              prev_link_i,
  input  wire  signed [PRIO_BITS-1:0] prev_prio_i,
  input  wire         [TAG_BITS-1:0]  prev_tag_i,
  input  wire                         next_valid_i,
  input  wire  signed [PRIO_BITS-1:0] next_prio_i,
  input  wire         [TAG_BITS-1:0]  next_tag_i,
  input  wire  signed [PRIO_BITS-1:0] head_prio_i,
  input  wire         [TAG_BITS-1:0]  head_tag_i,
  output spq_pkg::link_t              link_o,
  output logic signed [PRIO_BITS-1:0] prio_o,
  output logic        [TAG_BITS-1:0]  tag_o
);
  import spq_pkg::*;

  logic                        valid_q, valid_d;
  logic signed [PRIO_BITS-1:0] prio_q, prio_d;
  logic        [TAG_BITS-1:0]  tag_q, tag_d;
  logic                        keep;

  assign keep = valid_q && (prio_q >= ins_prio_i);

  always_comb begin
    valid_d = valid_q;
    prio_d  = prio_q;
    tag_d   = tag_q;
    case (op_i)
      OP_INSERT: begin
        if (!keep) begin
          if (prev_link_i.keep) begin
            // new entry lands here
            valid_d = 1'b1;
            prio_d  = ins_prio_i;
            tag_d   = ins_tag_i;
          end else begin
            // shift down from the neighbor above
            valid_d = prev_link_i.valid;
            prio_d  = prev_prio_i;
            tag_d   = prev_tag_i;
          end
        end
      end
      OP_ROTATE: begin
        // last valid slot wraps the head around
        if (valid_q) begin
          prio_d = next_valid_i ? next_prio_i : head_prio_i;
          tag_d  = next_valid_i ? next_tag_i : head_tag_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    tag_q  <= tag_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.keep  = keep;
  assign prio_o       = prio_q;
  assign tag_o        = tag_q;

endmodule
`default_nettype wire

// File: hdl/sorted_priority_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority store kept in descending order in a chain of slots.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries commands: mode 0 inserts (prio_in, tag_in), mode 1 dumps.
//   out_o carries results with status, last_flag and, on dump beats, the
//   entry's priority and tag. Entries of equal priority keep arrival order.
//   An insert answers with one beat (inserted, or dropped when all DEPTH
//   slots are full); the result is registered and shows on out_o the cycle
//   after the command beat. A dump of n entries produces n beats, one per
//   cycle while out_o is not stalled, by rotating the chain through slot 0;
//   after the last beat the chain is back in its original order. An empty
//   dump gives one beat with status empty. A new command is taken once the
//   previous one has produced all its beats and the output register is free
//   or being emptied, so inserts run at one per cycle while out_o accepts.
//   A stall on out_o holds the output register and freezes the rotation.
//   Reset empties the store; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
  parameter int unsigned DEPTH     = spq_pkg::DepthDef,
  parameter int unsigned PRIO_BITS = spq_pkg::PrioBitsDef,
  parameter int unsigned TAG_BITS  = spq_pkg::TagBitsDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_e;

  state_e                      state_q, state_d;
  logic   [CntW-1:0]           fill_q, fill_d;
  logic   [CntW-1:0]           remain_q, remain_d;
  logic                        out_valid_q, out_valid_d;
  logic signed [PRIO_BITS-1:0] out_prio_q, out_prio_d;
  logic        [TAG_BITS-1:0]  out_tag_q, out_tag_d;
  status_e                     out_status_q, out_status_d;
  logic                        out_last_q, out_last_d;

  logic     out_free, in_fire, dump_step, full, empty;
  cell_op_e op;

  link_t                       link   [DEPTH];
  logic signed [PRIO_BITS-1:0] c_prio [DEPTH];
  logic        [TAG_BITS-1:0]  c_tag  [DEPTH];

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_fire   = in_i.valid && in_i.ready;
  assign dump_step = (state_q == ST_DUMP) && out_free;
  assign full      = (fill_q == CntW'(DEPTH));
  assign empty     = (fill_q == '0);

  always_comb begin
    op = OP_HOLD;
    if (in_fire && !in_i.mode && !full) begin
      op = OP_INSERT;
    end else if ((in_fire && in_i.mode && !empty) || dump_step) begin
      op = OP_ROTATE;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    link_t                       prev_link;
    logic signed [PRIO_BITS-1:0] prev_prio;
    logic        [TAG_BITS-1:0]  prev_tag;
    logic                        next_valid;
    logic signed [PRIO_BITS-1:0] next_prio;
    logic        [TAG_BITS-1:0]  next_tag;

    if (g == 0) begin : g_first
      assign prev_link.valid = 1'b0;
      assign prev_link.keep  = 1'b1;
      assign prev_prio       = '0;
      assign prev_tag        = '0;
    end else begin : g_mid
      assign prev_link = link[g-1];
      assign prev_prio = c_prio[g-1];
      assign prev_tag  = c_tag[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_prio  = '0;
      assign next_tag   = '0;
    end else begin : g_inner
      assign next_valid = link[g+1].valid;
      assign next_prio  = c_prio[g+1];
      assign next_tag   = c_tag[g+1];
    end

    spq_cell #(
      .PRIO_BITS (PRIO_BITS),
      .TAG_BITS  (TAG_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (op),
      .ins_prio_i   (in_i.prio_in),
      .ins_tag_i    (in_i.tag_in),
      .prev_link_i  (prev_link),
      .prev_prio_i  (prev_prio),
      .prev_tag_i   (prev_tag),
      .next_valid_i (next_valid),
      .next_prio_i  (next_prio),
      .next_tag_i   (next_tag),
      .head_prio_i  (c_prio[0]),
      .head_tag_i   (c_tag[0]),
      .link_o       (link[g]),
      .prio_o       (c_prio[g]),
      .tag_o        (c_tag[g])
    );
  end

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    remain_d     = remain_q;
    out_valid_d  = out_valid_q;
    out_prio_d   = out_prio_q;
    out_tag_d    = out_tag_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (in_fire) begin
      out_valid_d = 1'b1;
      out_prio_d  = '0;
      out_tag_d   = '0;
      out_last_d  = 1'b1;
      if (!in_i.mode) begin
        out_status_d = full ? STAT_DROPPED : STAT_INSERTED;
        if (!full) begin
          fill_d = fill_q + CntW'(1);
        end
      end else if (empty) begin
        out_status_d = STAT_EMPTY;
      end else begin
        // emit the head now, rotate the rest out over the next cycles
        out_status_d = STAT_ENTRY;
        out_prio_d   = c_prio[0];
        out_tag_d    = c_tag[0];
        out_last_d   = (fill_q == CntW'(1));
        remain_d     = fill_q - CntW'(1);
        if (fill_q != CntW'(1)) begin
          state_d = ST_DUMP;
        end
      end
    end else if (dump_step) begin
      out_valid_d  = 1'b1;
      out_status_d = STAT_ENTRY;
      out_prio_d   = c_prio[0];
      out_tag_d    = c_tag[0];
      out_last_d   = (remain_q == CntW'(1));
      remain_d     = remain_q - CntW'(1);
      if (remain_q == CntW'(1)) begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_prio_q   <= out_prio_d;
    out_tag_q    <= out_tag_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.prio_out  = out_prio_q;
  assign out_o.tag_out   = out_tag_q;
  assign out_o.status    = out_status_q;
  assign out_o.last_flag = out_last_q;

endmodule
`default_nettype wire

// File: bench/spq_bench_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_bench_pkg
// Command codes shared by the queue testbench and its checker.
// ----------------------------------------------------------------------------
package spq_bench_pkg;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_DUMP   = 1'b1
  } mode_e;

endpackage

// File: bench/spq_order_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_order_checker
// Watches the command and result channels of the sorted priority queue,
// keeps its own sorted copy of the store and compares every result beat
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module spq_order_checker
  import spq_pkg::*;
  import spq_bench_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  spq_in_if    in_mon,
  spq_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   beats_checked_o
);

  typedef struct packed {
    logic signed [PrioBitsDef-1:0] prio;
    logic        [TagBitsDef-1:0]  tag;
    status_e                       status;
    logic                          last;
  } result_t;

  logic signed [PrioBitsDef-1:0] slot_prio [DepthDef];
  logic        [TagBitsDef-1:0]  slot_tag  [DepthDef];
  int                            fill_count;
  result_t                       awaited_results [$];
  result_t                       got;
  result_t                       want;

  function automatic result_t make_result(input logic signed [PrioBitsDef-1:0] prio,
                                          input logic [TagBitsDef-1:0] tag,
                                          input status_e status, input logic last);
    result_t r;
    r.prio   = prio;
    r.tag    = tag;
    r.status = status;
    r.last   = last;
    return r;
  endfunction

  task automatic predict_command(input mode_e mode,
                                 input logic signed [PrioBitsDef-1:0] prio,
                                 input logic [TagBitsDef-1:0] tag);
    int pos;
    int k;
    if (mode == MODE_INSERT) begin
      if (fill_count >= DepthDef) begin
        awaited_results.push_back(make_result('0, '0, STAT_DROPPED, 1'b1));
      end else begin
        // place after every entry of equal or higher priority
        pos = 0;
        while (pos < fill_count && slot_prio[pos] >= prio) pos++;
        for (k = fill_count; k > pos; k--) begin
          slot_prio[k] = slot_prio[k-1];
          slot_tag[k]  = slot_tag[k-1];
        end
        slot_prio[pos] = prio;
        slot_tag[pos]  = tag;
        fill_count++;
        awaited_results.push_back(make_result('0, '0, STAT_INSERTED, 1'b1));
      end
    end else if (fill_count == 0) begin
      awaited_results.push_back(make_result('0, '0, STAT_EMPTY, 1'b1));
    end else begin
      for (k = 0; k < fill_count; k++)
        awaited_results.push_back(make_result(slot_prio[k], slot_tag[k], STAT_ENTRY,
                                              k == fill_count - 1));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_count      = 0;
      fail_count_o    = 0;
      beats_checked_o = 0;
      awaited_results.delete();
    end else begin
      // results of this edge belong to earlier commands, so check them first
      if (out_mon.valid && out_mon.ready) begin
        got.prio   = out_mon.prio_out;
        got.tag    = out_mon.tag_out;
        got.status = status_e'(out_mon.status);
        got.last   = out_mon.last_flag;
        beats_checked_o++;
        if (awaited_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result beat: prio %0d tag %h status %0d last %b",
                   $time, got.prio, got.tag, got.status, got.last);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            fail_count_o++;
            $display("%0t: result mismatch: expected prio %0d tag %h status %0d last %b",
                     $time, want.prio, want.tag, want.status, want.last);
            $display("%0t:                  actual   prio %0d tag %h status %0d last %b",
                     $time, got.prio, got.tag, got.status, got.last);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_command(mode_e'(in_mon.mode), in_mon.prio_in, in_mon.tag_in);
    end
    pending_o = awaited_results.size();
  end

endmodule

// File: bench/sorted_priority_queue_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_test
// Drives insert and dump commands into the sorted priority queue under
// several idle and stall patterns, including a long output hold that backs
// up the input, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_test;
  import spq_pkg::*;
  import spq_bench_pkg::*;

  localparam int HalfPeriod  = 5;
  localparam int ResetCycles = 8;
  localparam int HoldCycles  = 120;
  localparam int IdleLimit   = 1000;
  localparam int DrainCycles = 20;
  localparam int PhaseItems  = 27;
  localparam int HoldItems   = 14;

  logic clk_i = 1'b0;
  logic rst_ni;

  spq_in_if  #(.PRIO_BITS(PrioBitsDef), .TAG_BITS(TagBitsDef)) in_bus  ();
  spq_out_if #(.PRIO_BITS(PrioBitsDef), .TAG_BITS(TagBitsDef)) out_bus ();

  int fail_count;
  int pending_count;
  int beats_checked;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_off_req   = 1'b0;
  int idle_cycles    = 0;
  int inserts_sent   = 0;
  int dumps_sent     = 0;

  always #HalfPeriod clk_i = ~clk_i;

  sorted_priority_queue_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  spq_order_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mon          (in_bus),
    .out_mon         (out_bus),
    .fail_count_o    (fail_count),
    .pending_o       (pending_count),
    .beats_checked_o (beats_checked)
  );

  task automatic send_beat(input mode_e m, input logic signed [PrioBitsDef-1:0] p,
                           input logic [TagBitsDef-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.mode    <= m;
    in_bus.prio_in <= p;
    in_bus.tag_in  <= t;
    if (m == MODE_DUMP) dumps_sent++;
    else inserts_sent++;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  task automatic send_random_item();
    mode_e                         m;
    logic signed [PrioBitsDef-1:0] p;
    logic        [TagBitsDef-1:0]  t;
    m = ($urandom_range(5) == 0) ? MODE_DUMP : MODE_INSERT;
    t = TagBitsDef'($urandom);
    case ($urandom_range(3))
      0: p = PrioBitsDef'(int'($urandom_range(4)) - 2);  // cluster near zero to force ties
      1: begin
        case ($urandom_range(3))
          0: p = {1'b0, {(PrioBitsDef-1){1'b1}}};
          1: p = {1'b1, {(PrioBitsDef-1){1'b0}}};
          2: p = '0;
          default: p = '1;
        endcase
      end
      default: p = PrioBitsDef'($urandom);
    endcase
    send_beat(m, p, t);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random_item();
  endtask

  // result receiver
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        // hold the output long enough for the input to back up
        hold_off_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no beat accepted for %0d cycles", $time, IdleLimit);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_bus.valid   <= 1'b0;
    in_bus.mode    <= MODE_INSERT;
    in_bus.prio_in <= '0;
    in_bus.tag_in  <= '0;
    rst_ni         <= 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty dump, extremes, ties at both ends and in the middle
    send_beat(MODE_DUMP,   '0, '0);
    send_beat(MODE_INSERT, 16'sh7fff, 16'hffff);
    send_beat(MODE_INSERT, 16'sh8000, 16'h0000);
    send_beat(MODE_INSERT, 16'sh0000, 16'h0001);
    send_beat(MODE_INSERT, 16'sh0000, 16'h0002);
    send_beat(MODE_INSERT, 16'sh7fff, 16'h0003);
    send_beat(MODE_INSERT, 16'sh8000, 16'h0004);
    send_beat(MODE_INSERT, -16'sd1,   16'haaaa);
    send_beat(MODE_INSERT, 16'sh0001, 16'h5555);
    send_beat(MODE_DUMP,   16'sh7fff, 16'hffff);

    run_phase(0, 0, PhaseItems);
    hold_off_req = 1'b1;
    run_phase(0, 0, HoldItems);
    run_phase(72, 0, PhaseItems);
    run_phase(0, 72, PhaseItems);
    run_phase(14, 14, PhaseItems);
    in_bus.valid <= 1'b0;

    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d inserts and %0d dumps, checked %0d result beats,",
             inserts_sent, dumps_sent, beats_checked);
    $display("over free-running, sender-idle, receiver-stall, mixed and long-hold phases.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
